/* rtl/ptqs_pkg.sv */
// Shared types, constants and helpers of the priority task queue scheduler.
package ptqs_pkg;

   // Default geometry of the level queues
   localparam int LEVEL_DEPTH_DEF = 256;
   localparam int LEVELS_DEF      = 4;

   // Field widths
   localparam int PRIO_W   = 2;
   localparam int TAG_W    = 16;
   localparam int DUR_W    = 24;
   localparam int SIZE_W   = 11;
   localparam int COUNT_W  = 6;
   localparam int DONE_W   = 32;
   localparam int CSR_A_W  = 1;
   localparam int REQ_D_W  = 48;
   localparam int RSP_D_W  = 112;

   // Saturation limits and reset values
   localparam logic [SIZE_W-1:0]  SIZE_MAX        = 11'd2047;
   localparam logic [COUNT_W-1:0] COUNT_MAX       = 6'd63;
   localparam logic [COUNT_W-1:0] MIN_WORKERS_RST = 6'd2;
   localparam logic [COUNT_W-1:0] MAX_WORKERS_RST = 6'd4;

   // Divide by ten: multiply by reciprocal, exact for dividends below 2^32
   localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
   localparam int          DIV10_SHIFT = 35;
   localparam logic [3:0]  AVG_ROUND   = 4'd5;

   // Item kinds
   typedef enum logic [1:0] {
      FUNC_SUBMIT = 2'd0,
      FUNC_TAKE   = 2'd1,
      FUNC_FINISH = 2'd2
   } func_type;

   // Configuration register indexes
   localparam logic [CSR_A_W-1:0] CSR_MIN_WORKERS = 1'b0;
   localparam logic [CSR_A_W-1:0] CSR_MAX_WORKERS = 1'b1;

   // Queue outcome of the transaction being accepted
   typedef struct packed {
      logic              taken;
      logic [PRIO_W-1:0] taken_priority;
      logic              dropped;
      logic [SIZE_W-1:0] size_next;
   } queue_status_type;

   // Per-transaction flags kept for the result
   typedef struct packed {
      logic              taken;
      logic [PRIO_W-1:0] taken_priority;
      logic              dropped;
      logic              scaled_up;
   } rsp_flags_type;

   // Clamp a queue total to the result field range
   function automatic logic [SIZE_W-1:0] sat_size(input logic [31:0] v);
      if (v > 32'(SIZE_MAX)) begin
         return SIZE_MAX;
      end
      return v[SIZE_W-1:0];
   endfunction

endpackage

/* rtl/ptqs_ram.sv */
// Generic simple dual-port RAM with registered read.
module ptqs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ptqs_queue.sv */
// Level queues: ring pointers, fill counts, priority pick and tag storage.
module ptqs_queue #(
   parameter int LEVELS      = ptqs_pkg::LEVELS_DEF,
   parameter int LEVEL_DEPTH = ptqs_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  ptqs_pkg::func_type                func,
   input  logic [ptqs_pkg::PRIO_W-1:0]       priority_req,
   input  logic [ptqs_pkg::TAG_W-1:0]        task_tag,
   output ptqs_pkg::queue_status_type        status,
   output logic [ptqs_pkg::TAG_W-1:0]        tag_out,
   output logic [ptqs_pkg::SIZE_W-1:0]       queue_size
);

   localparam int LVL_W  = $clog2(LEVELS);
   localparam int PTR_W  = $clog2(LEVEL_DEPTH);
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
   localparam int DEPTH  = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [PTR_W-1:0]  rd_ptr_ff [LEVELS];
   logic [PTR_W-1:0]  rd_ptr_in [LEVELS];
   logic [PTR_W-1:0]  wr_ptr_ff [LEVELS];
   logic [PTR_W-1:0]  wr_ptr_in [LEVELS];
   logic [CNT_W-1:0]  count_ff  [LEVELS];
   logic [CNT_W-1:0]  count_in  [LEVELS];
   logic [TOT_W-1:0]  total_ff;
   logic [TOT_W-1:0]  total_in;

   logic [LVL_W-1:0]  sub_lvl;
   logic [LVL_W-1:0]  top_lvl;
   logic              any_waiting;
   logic              full;
   logic              push;
   logic              pop;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // Advance a ring pointer with wrap at the level depth
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W:0] inc;
      inc = {1'b0, p} + 1'b1;
      if (inc >= (PTR_W+1)'(LEVEL_DEPTH)) begin
         return '0;
      end
      return inc[PTR_W-1:0];
   endfunction

   // Clamp submit level to the top level
   always_comb begin
      if (32'(priority_req) >= LEVELS) begin
         sub_lvl = LVL_W'(LEVELS - 1);
      end else begin
         sub_lvl = LVL_W'(priority_req);
      end
   end

   // Pick the highest non-empty level
   always_comb begin
      top_lvl     = '0;
      any_waiting = 1'b0;
      for (int i = 0; i < LEVELS; i++) begin
         if (count_ff[i] != '0) begin
            top_lvl     = LVL_W'(i);
            any_waiting = 1'b1;
         end
      end
   end

   assign full = (count_ff[sub_lvl] == CNT_W'(LEVEL_DEPTH));
   assign push = accept && (func == ptqs_pkg::FUNC_SUBMIT) && !full;
   assign pop  = accept && (func == ptqs_pkg::FUNC_TAKE) && any_waiting;

   // Next pointers and counts
   always_comb begin
      for (int i = 0; i < LEVELS; i++) begin
         rd_ptr_in[i] = rd_ptr_ff[i];
         wr_ptr_in[i] = wr_ptr_ff[i];
         count_in[i]  = count_ff[i];
         if (push && (sub_lvl == LVL_W'(i))) begin
            wr_ptr_in[i] = next_ptr(wr_ptr_ff[i]);
            count_in[i]  = count_ff[i] + 1'b1;
         end
         if (pop && (top_lvl == LVL_W'(i))) begin
            rd_ptr_in[i] = next_ptr(rd_ptr_ff[i]);
            count_in[i]  = count_ff[i] - 1'b1;
         end
      end
      total_in = total_ff + TOT_W'(push) - TOT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LEVELS; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
         total_ff <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
      end
   end

   // Tag storage: one region of LEVEL_DEPTH entries per level
   assign wr_addr = ADDR_W'(sub_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(wr_ptr_ff[sub_lvl]);
   assign rd_addr = ADDR_W'(top_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(rd_ptr_ff[top_lvl]);

   ptqs_ram #(
      .WIDTH(ptqs_pkg::TAG_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (push),
      .wr_addr(wr_addr),
      .wr_data(task_tag),
      .rd_en  (pop),
      .rd_addr(rd_addr),
      .rd_data(tag_out)
   );

   // Outcome of the transaction being accepted
   assign status.taken          = pop;
   assign status.taken_priority = pop ? ptqs_pkg::PRIO_W'(top_lvl) : '0;
   assign status.dropped        = accept && (func == ptqs_pkg::FUNC_SUBMIT) && full;
   assign status.size_next      = ptqs_pkg::sat_size(32'(total_in));

   assign queue_size = ptqs_pkg::sat_size(32'(total_ff));

endmodule

/* rtl/ptqs_stats.sv */
// Worker accounting, scale-up, finished count, run-time average and peak.
module ptqs_stats (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  ptqs_pkg::func_type                 func,
   input  logic [ptqs_pkg::DUR_W-1:0]         duration,
   input  ptqs_pkg::queue_status_type         status,
   input  logic                               csr_wen,
   input  logic [ptqs_pkg::CSR_A_W-1:0]       csr_addr,
   input  logic [ptqs_pkg::COUNT_W-1:0]       csr_wdata,
   output logic                               scaled_up,
   output logic [ptqs_pkg::COUNT_W-1:0]       worker_count,
   output logic [ptqs_pkg::COUNT_W-1:0]       busy_count,
   output logic [ptqs_pkg::DONE_W-1:0]        done_count,
   output logic [ptqs_pkg::DUR_W-1:0]         average_time,
   output logic [ptqs_pkg::SIZE_W-1:0]        high_water
);

   logic [ptqs_pkg::COUNT_W-1:0] max_workers_ff;
   logic [ptqs_pkg::COUNT_W-1:0] max_workers_in;
   logic [ptqs_pkg::COUNT_W-1:0] workers_ff;
   logic [ptqs_pkg::COUNT_W-1:0] workers_in;
   logic [ptqs_pkg::COUNT_W-1:0] busy_ff;
   logic [ptqs_pkg::COUNT_W-1:0] busy_in;
   logic [ptqs_pkg::DONE_W-1:0]  done_ff;
   logic [ptqs_pkg::DONE_W-1:0]  done_in;
   logic [ptqs_pkg::DUR_W-1:0]   avg_ff;
   logic [ptqs_pkg::DUR_W-1:0]   avg_in;
   logic [ptqs_pkg::SIZE_W-1:0]  peak_ff;
   logic [ptqs_pkg::SIZE_W-1:0]  peak_in;

   logic [27:0] avg_sum;
   logic [59:0] avg_prod;
   logic        scale_ok;

   // Weighted sum 9*avg + duration + 5, then divide by ten via reciprocal
   assign avg_sum  = 28'({avg_ff, 3'b000}) + 28'(avg_ff) + 28'(duration)
                   + 28'(ptqs_pkg::AVG_ROUND);
   assign avg_prod = 60'(avg_sum) * 60'(ptqs_pkg::DIV10_RECIP);

   // Scale up when waiting tasks exceed twice the workers, below the max
   assign scale_ok = (status.size_next > {4'b0000, workers_ff, 1'b0})
                   && (workers_ff < max_workers_ff)
                   && (workers_ff != ptqs_pkg::COUNT_MAX);

   // Next state per transaction kind and configuration writes
   always_comb begin
      max_workers_in = max_workers_ff;
      workers_in     = workers_ff;
      busy_in        = busy_ff;
      done_in        = done_ff;
      avg_in         = avg_ff;
      peak_in        = peak_ff;
      scaled_up      = 1'b0;
      if (accept) begin
         case (func)
            ptqs_pkg::FUNC_SUBMIT: begin
               if (status.size_next > peak_ff) begin
                  peak_in = status.size_next;
               end
               if (scale_ok) begin
                  workers_in = workers_ff + 1'b1;
                  scaled_up  = 1'b1;
               end
            end
            ptqs_pkg::FUNC_TAKE: begin
               if (status.taken && (busy_ff != ptqs_pkg::COUNT_MAX)) begin
                  busy_in = busy_ff + 1'b1;
               end
            end
            ptqs_pkg::FUNC_FINISH: begin
               if (busy_ff != '0) begin
                  busy_in = busy_ff - 1'b1;
               end
               done_in = done_ff + 1'b1;
               avg_in  = avg_prod[ptqs_pkg::DIV10_SHIFT +: ptqs_pkg::DUR_W];
            end
            default: begin
            end
         endcase
      end
      if (csr_wen) begin
         unique case (csr_addr)
            ptqs_pkg::CSR_MIN_WORKERS: workers_in     = csr_wdata;
            ptqs_pkg::CSR_MAX_WORKERS: max_workers_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_workers_ff <= ptqs_pkg::MAX_WORKERS_RST;
         workers_ff     <= ptqs_pkg::MIN_WORKERS_RST;
         busy_ff        <= '0;
         done_ff        <= '0;
         avg_ff         <= '0;
         peak_ff        <= '0;
      end else begin
         max_workers_ff <= max_workers_in;
         workers_ff     <= workers_in;
         busy_ff        <= busy_in;
         done_ff        <= done_in;
         avg_ff         <= avg_in;
         peak_ff        <= peak_in;
      end
   end

   assign worker_count = workers_ff;
   assign busy_count   = busy_ff;
   assign done_count   = done_ff;
   assign average_time = avg_ff;
   assign high_water   = peak_ff;

endmodule

/* rtl/priority_task_queue_scheduler.sv */
// Top level of the priority task queue scheduler: handshake and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser func, tdata level/tag/duration
//   rsp      out        rsp_tvalid/rsp_tready  tdata flags, take fields, status
//   csr      in         csr_wen                csr_addr index, csr_wdata value
//
// One transaction is taken per cycle; its result is presented on the next cycle
// from the result register and the status registers, with the taken tag read
// from the tag RAM's registered output. While a result waits on rsp_tready,
// req_tready stays low only if that result is not taken in the same cycle.
// Reset is synchronous; the tag RAM is not cleared and needs no start-up pass.
module priority_task_queue_scheduler #(
   parameter int LEVELS      = ptqs_pkg::LEVELS_DEF,
   parameter int LEVEL_DEPTH = ptqs_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // tuser: func[1:0]
   input  logic [1:0]                          req_tuser,
   // tdata: priority_req[1:0], task_tag[17:2], duration[41:18], zero fill
   input  logic [ptqs_pkg::REQ_D_W-1:0]        req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: taken[0], taken_priority[2:1], taken_tag[18:3], dropped[19],
   // scaled_up[20], queue_size[31:21], worker_count[37:32], busy_count[43:38],
   // done_count[75:44], average_time[99:76], high_water[110:100], zero fill
   output logic [ptqs_pkg::RSP_D_W-1:0]        rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wen,
   input  logic [ptqs_pkg::CSR_A_W-1:0]        csr_addr,
   input  logic [ptqs_pkg::COUNT_W-1:0]        csr_wdata
);

   logic                          accept;
   ptqs_pkg::func_type            func;
   ptqs_pkg::queue_status_type    status;
   logic [ptqs_pkg::TAG_W-1:0]    tag_out;
   logic [ptqs_pkg::SIZE_W-1:0]   queue_size;
   logic                          scaled_up;
   logic [ptqs_pkg::COUNT_W-1:0]  worker_count;
   logic [ptqs_pkg::COUNT_W-1:0]  busy_count;
   logic [ptqs_pkg::DONE_W-1:0]   done_count;
   logic [ptqs_pkg::DUR_W-1:0]    average_time;
   logic [ptqs_pkg::SIZE_W-1:0]   high_water;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   ptqs_pkg::rsp_flags_type       flags_ff;
   ptqs_pkg::rsp_flags_type       flags_in;

   // Accept when the result register is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign func       = ptqs_pkg::func_type'(req_tuser);

   ptqs_queue #(
      .LEVELS     (LEVELS),
      .LEVEL_DEPTH(LEVEL_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (func),
      .priority_req(req_tdata[1:0]),
      .task_tag    (req_tdata[17:2]),
      .status      (status),
      .tag_out     (tag_out),
      .queue_size  (queue_size)
   );

   ptqs_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .func        (func),
      .duration    (req_tdata[41:18]),
      .status      (status),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .scaled_up   (scaled_up),
      .worker_count(worker_count),
      .busy_count  (busy_count),
      .done_count  (done_count),
      .average_time(average_time),
      .high_water  (high_water)
   );

   // Load flags on accept, drop valid once the transaction is taken
   always_comb begin
      flags_in     = flags_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         flags_in.taken          = status.taken;
         flags_in.taken_priority = status.taken_priority;
         flags_in.dropped        = status.dropped;
         flags_in.scaled_up      = scaled_up;
         rsp_valid_in            = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   // Pack the result
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0,
                        high_water,
                        average_time,
                        done_count,
                        busy_count,
                        worker_count,
                        queue_size,
                        flags_ff.scaled_up,
                        flags_ff.dropped,
                        (flags_ff.taken ? tag_out : {ptqs_pkg::TAG_W{1'b0}}),
                        flags_ff.taken_priority,
                        flags_ff.taken};

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the priority task queue scheduler.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REQ_USED    = ptqs_pkg::PRIO_W + ptqs_pkg::TAG_W + ptqs_pkg::DUR_W;
   localparam int CYCLE_LIMIT = 500000;
   // Item kind that the block treats as a no-op status read
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // One result, field by field
   typedef struct packed {
      logic                         taken;
      logic [ptqs_pkg::PRIO_W-1:0]  taken_priority;
      logic [ptqs_pkg::TAG_W-1:0]   taken_tag;
      logic                         dropped;
      logic                         scaled_up;
      logic [ptqs_pkg::SIZE_W-1:0]  queue_size;
      logic [ptqs_pkg::COUNT_W-1:0] worker_count;
      logic [ptqs_pkg::COUNT_W-1:0] busy_count;
      logic [ptqs_pkg::DONE_W-1:0]  done_count;
      logic [ptqs_pkg::DUR_W-1:0]   average_time;
      logic [ptqs_pkg::SIZE_W-1:0]  high_water;
   } sched_result_type;

   logic                           clock;
   logic                           reset;
   logic [1:0]                     req_tuser;
   logic [ptqs_pkg::REQ_D_W-1:0]   req_tdata;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ptqs_pkg::RSP_D_W-1:0]   rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic                           csr_wen;
   logic [ptqs_pkg::CSR_A_W-1:0]   csr_addr;
   logic [ptqs_pkg::COUNT_W-1:0]   csr_wdata;

   // Scheduler state as the testbench expects it
   logic [ptqs_pkg::TAG_W-1:0]     level_q [ptqs_pkg::LEVELS_DEF][$];
   logic [ptqs_pkg::COUNT_W-1:0]   pred_max;
   logic [ptqs_pkg::COUNT_W-1:0]   pred_workers;
   logic [ptqs_pkg::COUNT_W-1:0]   pred_busy;
   logic [ptqs_pkg::DONE_W-1:0]    pred_done;
   logic [ptqs_pkg::DUR_W-1:0]     pred_avg;
   logic [ptqs_pkg::SIZE_W-1:0]    pred_peak;

   sched_result_type     pending_results [$];
   int                   errors = 0;
   int                   cycle_count = 0;
   bit                   burst_mode = 1'b0;

   priority_task_queue_scheduler DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic int queued_total();
      int sum;
      sum = 0;
      for (int i = 0; i < ptqs_pkg::LEVELS_DEF; i++) begin
         sum += level_q[i].size();
      end
      return sum;
   endfunction

   function automatic logic [ptqs_pkg::SIZE_W-1:0] clamp_size(input int v);
      if (v > int'(ptqs_pkg::SIZE_MAX)) begin
         return ptqs_pkg::SIZE_MAX;
      end
      return ptqs_pkg::SIZE_W'(v);
   endfunction

   // Advance the expected state by one accepted transaction and queue its result
   function automatic void predict_schedule(input logic [1:0] kind,
                                            input logic [ptqs_pkg::PRIO_W-1:0] level,
                                            input logic [ptqs_pkg::TAG_W-1:0] tag,
                                            input logic [ptqs_pkg::DUR_W-1:0] dur);
      sched_result_type r;
      logic [ptqs_pkg::SIZE_W-1:0] size;
      logic [31:0] acc;
      r = '0;
      case (kind)
         ptqs_pkg::FUNC_SUBMIT: begin
            if (level_q[level].size() >= ptqs_pkg::LEVEL_DEPTH_DEF) begin
               r.dropped = 1'b1;
            end else begin
               level_q[level].push_back(tag);
            end
            size = clamp_size(queued_total());
            if (size > pred_peak) begin
               pred_peak = size;
            end
            if (int'(size) > 2 * int'(pred_workers) && pred_workers < pred_max &&
                pred_workers < ptqs_pkg::COUNT_MAX) begin
               pred_workers = pred_workers + 1'b1;
               r.scaled_up  = 1'b1;
            end
         end
         ptqs_pkg::FUNC_TAKE: begin
            for (int i = ptqs_pkg::LEVELS_DEF - 1; i >= 0; i--) begin
               if (!r.taken && level_q[i].size() != 0) begin
                  r.taken          = 1'b1;
                  r.taken_priority = ptqs_pkg::PRIO_W'(i);
                  r.taken_tag      = level_q[i].pop_front();
                  if (pred_busy < ptqs_pkg::COUNT_MAX) begin
                     pred_busy = pred_busy + 1'b1;
                  end
               end
            end
         end
         ptqs_pkg::FUNC_FINISH: begin
            if (pred_busy != 0) begin
               pred_busy = pred_busy - 1'b1;
            end
            pred_done = pred_done + 1'b1;
            acc = 32'd9 * 32'(pred_avg) + 32'(dur) + 32'(ptqs_pkg::AVG_ROUND);
            pred_avg = ptqs_pkg::DUR_W'(acc / 32'd10);
         end
         default: begin
         end
      endcase
      r.queue_size   = clamp_size(queued_total());
      r.worker_count = pred_workers;
      r.busy_count   = pred_busy;
      r.done_count   = pred_done;
      r.average_time = pred_avg;
      r.high_water   = pred_peak;
      pending_results.push_back(r);
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("taken", 32'(want.taken), 32'(rsp_tdata[0]));
            check_field("taken_priority", 32'(want.taken_priority), 32'(rsp_tdata[2:1]));
            check_field("taken_tag", 32'(want.taken_tag), 32'(rsp_tdata[18:3]));
            check_field("dropped", 32'(want.dropped), 32'(rsp_tdata[19]));
            check_field("scaled_up", 32'(want.scaled_up), 32'(rsp_tdata[20]));
            check_field("queue_size", 32'(want.queue_size), 32'(rsp_tdata[31:21]));
            check_field("worker_count", 32'(want.worker_count), 32'(rsp_tdata[37:32]));
            check_field("busy_count", 32'(want.busy_count), 32'(rsp_tdata[43:38]));
            check_field("done_count", want.done_count, rsp_tdata[75:44]);
            check_field("average_time", 32'(want.average_time), 32'(rsp_tdata[99:76]));
            check_field("high_water", 32'(want.high_water), 32'(rsp_tdata[110:100]));
            check_field("zero fill", 32'd0, 32'(rsp_tdata[ptqs_pkg::RSP_D_W-1:111]));
         end
      end
   end

   // Stall the result side for a random number of cycles per transaction
   initial begin : accept_results
      int stall;
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         stall = burst_mode ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Send one request transaction after a random gap
   task automatic send_item(input logic [1:0] kind,
                            input logic [ptqs_pkg::PRIO_W-1:0] level,
                            input logic [ptqs_pkg::TAG_W-1:0] tag,
                            input logic [ptqs_pkg::DUR_W-1:0] dur);
      int gap;
      gap = burst_mode ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= kind;
      req_tdata  <= {{(ptqs_pkg::REQ_D_W - REQ_USED){1'b0}}, dur, tag, level};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_schedule(kind, level, tag, dur);
   endtask

   // Hold off the sender until every result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write one register, then leave the port idle
   task automatic write_csr(input logic [ptqs_pkg::CSR_A_W-1:0] index,
                            input logic [ptqs_pkg::COUNT_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == ptqs_pkg::CSR_MIN_WORKERS) begin
         pred_workers = value;
      end else begin
         pred_max = value;
      end
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Extremes of every field, each item kind, ordering across levels, rounding
   task automatic test_directed();
      send_item(ptqs_pkg::FUNC_TAKE, 2'd0, 16'h0000, 24'd0);
      send_item(ptqs_pkg::FUNC_FINISH, 2'd0, 16'h0000, 24'd0);
      send_item(FUNC_UNUSED, 2'd3, 16'hFFFF, 24'hFFFFFF);
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd0, 16'h0000, 24'd0);
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd1, 16'hFFFF, 24'hFFFFFF);
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd2, 16'h5A5A, 24'd0);
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd3, 16'hFFFF, 24'd0);
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd3, 16'h0000, 24'd0);
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd0, 16'hA5A5, 24'd0);
      send_item(FUNC_UNUSED, 2'd0, 16'h0000, 24'd0);
      repeat (7) send_item(ptqs_pkg::FUNC_TAKE, 2'd3, 16'hFFFF, 24'hFFFFFF);
      send_item(ptqs_pkg::FUNC_FINISH, 2'd0, 16'h0000, 24'hFFFFFF);
      send_item(ptqs_pkg::FUNC_FINISH, 2'd3, 16'hFFFF, 24'hFFFFFF);
      send_item(ptqs_pkg::FUNC_FINISH, 2'd0, 16'h0000, 24'd5);
      send_item(ptqs_pkg::FUNC_FINISH, 2'd0, 16'h0000, 24'd1);
      send_item(ptqs_pkg::FUNC_FINISH, 2'd0, 16'h0000, 24'd0);
   endtask

   // Fill the low level past full, then take everything back out
   task automatic test_level_full();
      wait_drained();
      write_csr(ptqs_pkg::CSR_MIN_WORKERS, 6'd1);
      write_csr(ptqs_pkg::CSR_MAX_WORKERS, 6'd63);
      burst_mode = 1'b1;
      while (level_q[0].size() < ptqs_pkg::LEVEL_DEPTH_DEF) begin
         send_item(ptqs_pkg::FUNC_SUBMIT, 2'd0, ptqs_pkg::TAG_W'($urandom),
                   ptqs_pkg::DUR_W'($urandom));
      end
      repeat (2) send_item(ptqs_pkg::FUNC_SUBMIT, 2'd0, ptqs_pkg::TAG_W'($urandom),
                           ptqs_pkg::DUR_W'($urandom));
      // A full low level leaves the critical level open
      send_item(ptqs_pkg::FUNC_SUBMIT, 2'd3, ptqs_pkg::TAG_W'($urandom),
                ptqs_pkg::DUR_W'($urandom));
      burst_mode = 1'b0;
      wait_drained();
      while (queued_total() != 0) begin
         send_item(ptqs_pkg::FUNC_TAKE, ptqs_pkg::PRIO_W'($urandom),
                   ptqs_pkg::TAG_W'($urandom), ptqs_pkg::DUR_W'($urandom));
      end
      send_item(ptqs_pkg::FUNC_TAKE, 2'd0, 16'h0000, 24'd0);
   endtask

   // Random traffic under several register settings, extremes included
   task automatic test_random_phases();
      logic [ptqs_pkg::COUNT_W-1:0] set_min;
      logic [ptqs_pkg::COUNT_W-1:0] set_max;
      logic [1:0] kind;
      logic [ptqs_pkg::DUR_W-1:0] dur;
      int roll;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin set_min = 6'd63; set_max = 6'd63; end
            1: begin set_min = 6'd0;  set_max = 6'd0;  end
            2: begin set_min = 6'd63; set_max = 6'd1;  end
            3: begin set_min = 6'd1;  set_max = 6'd63; end
            default: begin
               set_min = ptqs_pkg::COUNT_W'($urandom_range(1, 8));
               set_max = ptqs_pkg::COUNT_W'($urandom_range(1, 63));
            end
         endcase
         wait_drained();
         if (p % 2 == 0) begin
            write_csr(ptqs_pkg::CSR_MIN_WORKERS, set_min);
            write_csr(ptqs_pkg::CSR_MAX_WORKERS, set_max);
         end else begin
            write_csr(ptqs_pkg::CSR_MAX_WORKERS, set_max);
            write_csr(ptqs_pkg::CSR_MIN_WORKERS, set_min);
         end
         for (int n = 0; n < 52; n++) begin
            // Switch between back-to-back stretches and random gaps
            if (n % 20 == 0) begin
               burst_mode = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               kind = ptqs_pkg::FUNC_SUBMIT;
            end else if (roll < 80) begin
               kind = ptqs_pkg::FUNC_TAKE;
            end else if (roll < 95) begin
               kind = ptqs_pkg::FUNC_FINISH;
            end else begin
               kind = FUNC_UNUSED;
            end
            case ($urandom_range(0, 3))
               0: dur = '0;
               1: dur = '1;
               2: dur = ptqs_pkg::DUR_W'($urandom_range(0, 255));
               default: dur = ptqs_pkg::DUR_W'($urandom);
            endcase
            send_item(kind, ptqs_pkg::PRIO_W'($urandom), ptqs_pkg::TAG_W'($urandom), dur);
         end
      end
      burst_mode = 1'b0;
   endtask

   initial begin
      pred_max     = ptqs_pkg::MAX_WORKERS_RST;
      pred_workers = ptqs_pkg::MIN_WORKERS_RST;
      pred_busy    = '0;
      pred_done    = '0;
      pred_avg     = '0;
      pred_peak    = '0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_addr   <= '0;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_level_full();
      test_random_phases();
      wait_drained();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/ptqs_pkg.sv
rtl/ptqs_ram.sv
rtl/ptqs_queue.sv
rtl/ptqs_stats.sv
rtl/priority_task_queue_scheduler.sv
sim/testbench.sv
